// ===== hw/rtl/mtf_pkg.sv =====
`default_nettype none

package mtf_pkg;

    // List geometry
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LEN_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int POS_W  = 6;

    // Stream widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    // Command codes carried on s_tuser
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Status from the shared compare/address unit to the sequencer
    typedef struct packed {
        logic              hit;    // read word equals the search value
        logic              last;   // pointer is at the tail of the list
        logic              first;  // pointer is at the front of the list
        logic [ADDR_W-1:0] inc;    // pointer + 1
        logic [ADDR_W-1:0] dec;    // pointer - 1
    } step_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mtf_ram.sv =====
`default_nettype none

module mtf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mtf_scan_unit.sv =====
`default_nettype none

module mtf_scan_unit (
    input  wire logic [mtf_pkg::WORD_W-1:0] rd_word,
    input  wire logic [mtf_pkg::WORD_W-1:0] key,
    input  wire logic [mtf_pkg::ADDR_W-1:0] ptr,
    input  wire logic [mtf_pkg::LEN_W-1:0]  len,
    output mtf_pkg::step_t                  step
);

    // Shared comparator and pointer arithmetic, used by scan and shift alike
    always_comb begin
        step.hit   = (rd_word == key);
        step.last  = ((mtf_pkg::LEN_W'(ptr) + mtf_pkg::LEN_W'(1)) == len);
        step.first = (ptr == '0);
        step.inc   = ptr + mtf_pkg::ADDR_W'(1);
        step.dec   = ptr - mtf_pkg::ADDR_W'(1);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/move_to_front_list_search.sv =====
// Channel | Handshake          | tdata                  | tuser
// s_      | s_tvalid/s_tready  | [31:0] value (signed)  | [0] command (0 load, 1 query)
// m_      | m_tvalid/m_tready  | [5:0] position         | [0] found
//
// A load appends at the tail unless full. A query scans from the front to a hit
// or the tail, shifts the words ahead of a hit back one place, then writes the hit
// to the front and offers the result; the list RAM has one read and one write port.
// aresetn empties the list; RAM contents are not cleared.
// s_tready is low while a query is in flight; a held result stalls the
// block only when the next query finishes.
`default_nettype none

module move_to_front_list_search (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [mtf_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] value
    input  wire logic [0:0]                    s_tuser,   // [0] command
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [mtf_pkg::M_TDATA_W-1:0] m_tdata,   // [5:0] position
    output logic      [0:0]                    m_tuser    // [0] found
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [mtf_pkg::ADDR_W-1:0]   ptr_reg, ptr_next;
    logic [mtf_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [mtf_pkg::WORD_W-1:0]   val_reg, val_next;
    logic                         found_reg, found_next;
    logic [mtf_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic                         m_found_reg, m_found_next;
    logic [mtf_pkg::POS_W-1:0]    m_pos_reg, m_pos_next;

    logic                         ram_we;
    logic [mtf_pkg::ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [mtf_pkg::WORD_W-1:0]   ram_wdata, ram_rdata;
    mtf_pkg::step_t               step;
    logic                         s_word;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_word   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = mtf_pkg::M_TDATA_W'(m_pos_reg);
    assign m_tuser  = m_found_reg;

    mtf_ram #(
        .WIDTH (mtf_pkg::WORD_W),
        .DEPTH (mtf_pkg::DEPTH)
    ) u_list (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mtf_scan_unit u_unit (
        .rd_word (ram_rdata),
        .key     (val_reg),
        .ptr     (ptr_reg),
        .len     (len_reg),
        .step    (step)
    );

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        len_next      = len_reg;
        val_next      = val_reg;
        found_next    = found_reg;
        pos_next      = pos_reg;
        m_tvalid_next = m_tvalid_reg;
        m_found_next  = m_found_reg;
        m_pos_next    = m_pos_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = val_reg;
        ram_raddr     = '0;

        // result word leaves
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_word) begin
                    val_next = s_tdata;
                    ptr_next = '0;
                    if (s_tuser[0] == mtf_pkg::CMD_LOAD) begin
                        // append at the tail unless full
                        if (len_reg < mtf_pkg::LEN_W'(mtf_pkg::DEPTH)) begin
                            ram_we    = 1'b1;
                            ram_waddr = mtf_pkg::ADDR_W'(len_reg);
                            ram_wdata = s_tdata;
                            len_next  = len_reg + mtf_pkg::LEN_W'(1);
                        end
                    end else begin
                        found_next = 1'b0;
                        pos_next   = '0;
                        state_next = (len_reg == '0) ? ST_DONE : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // word at ptr_reg is on the read port
                if (step.hit) begin
                    found_next = 1'b1;
                    pos_next   = mtf_pkg::POS_W'(ptr_reg);
                    if (step.first) begin
                        state_next = ST_DONE;
                    end else begin
                        ram_raddr  = step.dec;
                        ptr_next   = step.dec;
                        state_next = ST_SHIFT;
                    end
                end else if (step.last) begin
                    state_next = ST_DONE;
                end else begin
                    ram_raddr = step.inc;
                    ptr_next  = step.inc;
                end
            end
            ST_SHIFT: begin
                // move word at ptr_reg back by one
                ram_we    = 1'b1;
                ram_waddr = step.inc;
                ram_wdata = ram_rdata;
                ram_raddr = step.dec;
                ptr_next  = step.dec;
                if (step.first) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // put the hit at the front; rewriting while stalled is harmless
                ram_we    = found_reg;
                ram_waddr = '0;
                ram_wdata = val_reg;
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_found_next  = found_reg;
                    m_pos_next    = pos_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            len_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        ptr_reg     <= ptr_next;
        val_reg     <= val_next;
        found_reg   <= found_next;
        pos_reg     <= pos_next;
        m_found_reg <= m_found_next;
        m_pos_reg   <= m_pos_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mtf_checker.sv =====
`default_nettype none

module mtf_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [0:0]                    s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [mtf_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [0:0]                    m_tuser
);

    // Stalled result word stays offered
    a_m_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word withdrawn while stalled");

    // Stalled result word keeps its payload
    a_m_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A miss always reports position zero
    a_miss_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("miss with non-zero position");

    // A query keeps the input closed for at least the next cycle
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == mtf_pkg::CMD_QUERY |=> !s_tready)
        else $error("input open straight after a query");

    // Nothing is offered right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word offered after reset");

endmodule

bind move_to_front_list_search mtf_checker u_mtf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
